// ===== rtl/nsl_pkg.sv =====
// shared types and constants for the nearest symbol lookup block
`default_nettype none

package nsl_pkg;

	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 64;

	// register indexes, taken from paddr[3]
	localparam logic RegQueryAddr = 1'b0;

	localparam logic [7:0] TypeMask   = 8'h0F;
	localparam logic [3:0] TypeNone   = 4'd0;
	localparam logic [3:0] TypeObject = 4'd1;
	localparam logic [3:0] TypeFunc   = 4'd2;

	// classified entry passed from the front to the back
	typedef struct packed {
		logic        eligible;
		logic        contain;
		logic        last;
		logic [63:0] value;
		logic [63:0] size;
		logic [7:0]  info;
		logic [15:0] section;
		logic [31:0] name_ref;
		logic [63:0] delta;
	} cls_word_t;

endpackage

`default_nettype wire

// ===== rtl/nsl_if.sv =====
// stream interfaces for symbol entries and lookup results
`default_nettype none

interface nsl_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] sym_value;
	logic [63:0] sym_size;
	logic [7:0]  sym_info;
	logic [15:0] sym_section;
	logic [31:0] name_ref;
	logic        has_name;
	logic        last_entry;

	modport source (
		output valid, sym_value, sym_size, sym_info, sym_section, name_ref,
			has_name, last_entry,
		input ready
	);
	modport sink (
		input valid, sym_value, sym_size, sym_info, sym_section, name_ref,
			has_name, last_entry,
		output ready
	);
endinterface

interface nsl_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic        contains;
	logic [63:0] match_value;
	logic [63:0] match_size;
	logic [7:0]  match_info;
	logic [15:0] match_section;
	logic [31:0] match_name_ref;
	logic [63:0] addr_offset;

	modport source (
		output valid, found, contains, match_value, match_size, match_info,
			match_section, match_name_ref, addr_offset,
		input ready
	);
	modport sink (
		input valid, found, contains, match_value, match_size, match_info,
			match_section, match_name_ref, addr_offset,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/nsl_front.sv =====
// front end: accepts symbol entries and classifies them against the query address
`default_nettype none

module nsl_front (
	nsl_in_if.sink            entry,
	input  wire logic [63:0]  query_addr,
	input  wire logic         queue_full,
	output nsl_pkg::cls_word_t push_word,
	output logic              push
);
	import nsl_pkg::*;

	logic [3:0]  sym_type;
	logic        type_ok;
	logic [63:0] range_end;

	assign entry.ready = !queue_full;
	assign push        = entry.valid && entry.ready;

	assign sym_type  = 4'(entry.sym_info & TypeMask);
	assign type_ok   = (sym_type == TypeNone) || (sym_type == TypeObject) ||
		(sym_type == TypeFunc);
	// end of range wraps modulo 2^64
	assign range_end = entry.sym_value + entry.sym_size;

	always_comb begin
		push_word.eligible = entry.has_name && (entry.sym_section != 16'd0) &&
			(query_addr >= entry.sym_value) && type_ok;
		push_word.contain  = (entry.sym_size != 64'd0) && (query_addr < range_end);
		push_word.last     = entry.last_entry;
		push_word.value    = entry.sym_value;
		push_word.size     = entry.sym_size;
		push_word.info     = entry.sym_info;
		push_word.section  = entry.sym_section;
		push_word.name_ref = entry.name_ref;
		push_word.delta    = query_addr - entry.sym_value;
	end

endmodule

`default_nettype wire

// ===== rtl/nsl_queue.sv =====
// small queue of classified entries between the front and the back
`default_nettype none

module nsl_queue #(
	parameter int unsigned Depth = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire nsl_pkg::cls_word_t push_word,
	output logic                    full,
	input  wire logic               pop,
	output nsl_pkg::cls_word_t      pop_word,
	output logic                    empty
);
	import nsl_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cls_word_t         mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full     = (count_q == CntW'(Depth));
	assign empty    = (count_q == '0);
	assign pop_word = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		if (p == PtrW'(Depth - 1)) begin
			return '0;
		end
		return p + PtrW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/nsl_back.sv =====
// back end: keeps the running best match and emits the result on the last entry
`default_nettype none

module nsl_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nsl_pkg::cls_word_t word,
	input  wire logic               queue_empty,
	output logic                    pop,
	nsl_out_if.source               result
);
	import nsl_pkg::*;

	logic        have_cont_q;
	logic        have_prec_q;
	logic [63:0] best_start_q;
	logic [63:0] best_length_q;
	logic [7:0]  best_info_q;
	logic [15:0] best_section_q;
	logic [31:0] best_name_q;
	logic [63:0] best_delta_q;

	logic        out_valid_q;
	logic        found_q;
	logic        contains_q;
	logic [63:0] value_q;
	logic [63:0] size_q;
	logic [7:0]  info_q;
	logic [15:0] section_q;
	logic [31:0] name_q;
	logic [63:0] offset_q;

	logic        higher;
	logic        take_cont;
	logic        take_prec;
	logic        take;
	logic        nxt_cont;
	logic        nxt_prec;
	logic [63:0] nxt_start;
	logic [63:0] nxt_length;
	logic [7:0]  nxt_info;
	logic [15:0] nxt_section;
	logic [31:0] nxt_name;
	logic [63:0] nxt_delta;

	// only a last word needs the output register, which frees up as the
	// current result is taken
	assign pop = !queue_empty && (!word.last || !out_valid_q || result.ready);

	assign higher    = word.value > best_start_q;
	assign take_cont = word.eligible && word.contain && (!have_cont_q || higher);
	assign take_prec = word.eligible && !word.contain && !have_cont_q &&
		(!have_prec_q || higher);
	assign take      = take_cont || take_prec;

	assign nxt_cont    = have_cont_q || take_cont;
	assign nxt_prec    = have_prec_q || take_prec;
	assign nxt_start   = take ? word.value    : best_start_q;
	assign nxt_length  = take ? word.size     : best_length_q;
	assign nxt_info    = take ? word.info     : best_info_q;
	assign nxt_section = take ? word.section  : best_section_q;
	assign nxt_name    = take ? word.name_ref : best_name_q;
	assign nxt_delta   = take ? word.delta    : best_delta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_cont_q    <= 1'b0;
			have_prec_q    <= 1'b0;
			best_start_q   <= '0;
			best_length_q  <= '0;
			best_info_q    <= '0;
			best_section_q <= '0;
			best_name_q    <= '0;
			best_delta_q   <= '0;
		end else if (pop) begin
			if (word.last) begin
				// search done, start fresh
				have_cont_q    <= 1'b0;
				have_prec_q    <= 1'b0;
				best_start_q   <= '0;
				best_length_q  <= '0;
				best_info_q    <= '0;
				best_section_q <= '0;
				best_name_q    <= '0;
				best_delta_q   <= '0;
			end else begin
				have_cont_q    <= nxt_cont;
				have_prec_q    <= nxt_prec;
				best_start_q   <= nxt_start;
				best_length_q  <= nxt_length;
				best_info_q    <= nxt_info;
				best_section_q <= nxt_section;
				best_name_q    <= nxt_name;
				best_delta_q   <= nxt_delta;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && word.last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// best fields stay zero until something is taken, so no match reads as zeros
	always_ff @(posedge clk) begin
		if (pop && word.last) begin
			found_q    <= nxt_cont || nxt_prec;
			contains_q <= nxt_cont;
			value_q    <= nxt_start;
			size_q     <= nxt_length;
			info_q     <= nxt_info;
			section_q  <= nxt_section;
			name_q     <= nxt_name;
			offset_q   <= nxt_delta;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.found          = found_q;
	assign result.contains       = contains_q;
	assign result.match_value    = value_q;
	assign result.match_size     = size_q;
	assign result.match_info     = info_q;
	assign result.match_section  = section_q;
	assign result.match_name_ref = name_q;
	assign result.addr_offset    = offset_q;

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && word.last) |=> (!have_cont_q && !have_prec_q && best_start_q == '0))
		else $error("state not cleared after last entry");
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop && word.last))
		else $error("result raised without a last entry");
`endif

endmodule

`default_nettype wire

// ===== rtl/nearest_symbol_lookup.sv =====
// nearest_symbol_lookup: one symbol entry per cycle while the queue is not full; the last
// entry is written into the queue and its result is then registered in the back end
// the classify compare sits in the front and the best-start compare in the back,
// with a queue of QueueDepth words between them
// arst_n clears the query address, the running best match, the queue and the
// result valid; the search state is also cleared after each last entry
`default_nettype none

module nearest_symbol_lookup #(
	parameter int unsigned QueueDepth = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [nsl_pkg::AddrWidth-1:0]    paddr,
	input  wire logic [nsl_pkg::DataWidth-1:0]    pwdata,
	output logic      [nsl_pkg::DataWidth-1:0]    prdata,
	output logic                                  pready,
	nsl_in_if.sink                                entry,
	nsl_out_if.source                             result
);
	import nsl_pkg::*;

	logic [63:0] query_addr_q;
	logic        reg_index;
	logic        cfg_write;
	cls_word_t   push_word;
	cls_word_t   pop_word;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;

	assign pready    = 1'b1;
	assign reg_index = paddr[3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_addr_q <= '0;
		end else if (cfg_write && reg_index == RegQueryAddr) begin
			query_addr_q <= pwdata;
		end
	end

	always_comb begin
		unique case (reg_index)
			RegQueryAddr: prdata = query_addr_q;
			default:      prdata = '0;
		endcase
	end

	nsl_front u_front (
		.entry      (entry),
		.query_addr (query_addr_q),
		.queue_full (full),
		.push_word  (push_word),
		.push       (push)
	);

	nsl_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty)
	);

	nsl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.word        (pop_word),
		.queue_empty (empty),
		.pop         (pop),
		.result      (result)
	);

endmodule

`default_nettype wire

// ===== dv/tb_nearest_symbol_lookup.sv =====
// testbench for the nearest symbol lookup block: directed and random searches
`timescale 1ns / 100ps

module tb_nearest_symbol_lookup;

	import nsl_pkg::*;

	localparam int unsigned DrainCycles  = 10;
	localparam int unsigned IdleLimit    = 3000;
	localparam int unsigned RandomItems  = 530;
	localparam logic [AddrWidth-1:0] QueryAddrOffset = {RegQueryAddr, 3'b000};

	typedef struct packed {
		logic [63:0] value;
		logic [63:0] size;
		logic [7:0]  info;
		logic [15:0] section;
		logic [31:0] name_ref;
		logic        has_name;
		logic        last_entry;
	} sym_entry_t;

	typedef struct packed {
		logic        found;
		logic        contains;
		logic [63:0] match_value;
		logic [63:0] match_size;
		logic [7:0]  match_info;
		logic [15:0] match_section;
		logic [31:0] match_name_ref;
		logic [63:0] addr_offset;
	} lookup_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;

	nsl_in_if  entry_if ();
	nsl_out_if result_if ();

	nearest_symbol_lookup i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.entry   (entry_if),
		.result  (result_if)
	);

	always #6 clk = ~clk;

	// running search state of the predictor
	logic [63:0]  query_val;
	logic         have_cont;
	logic         have_prec;
	lookup_t      best;
	lookup_t      lookups_due[$];

	int unsigned  mismatches;
	int unsigned  quiet_cycles;
	int unsigned  hold_left;
	bit           gaps_on;
	bit           stalls_on;

	function automatic int unsigned pick_gap(input bit on);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic sym_entry_t mk_sym(input logic [63:0] value, input logic [63:0] size,
			input logic [7:0] info, input logic [15:0] section, input logic [31:0] name_ref,
			input logic has_name, input logic last_entry);
		sym_entry_t e;
		e.value      = value;
		e.size       = size;
		e.info       = info;
		e.section    = section;
		e.name_ref   = name_ref;
		e.has_name   = has_name;
		e.last_entry = last_entry;
		return e;
	endfunction

	function automatic lookup_t capture(input sym_entry_t e, input logic [63:0] q);
		lookup_t m;
		m                = '0;
		m.match_value    = e.value;
		m.match_size     = e.size;
		m.match_info     = e.info;
		m.match_section  = e.section;
		m.match_name_ref = e.name_ref;
		m.addr_offset    = q - e.value;
		return m;
	endfunction

	// fold one accepted entry into the running best match
	task automatic track_nearest(input sym_entry_t e);
		logic [7:0]  typ;
		logic [63:0] end_addr;
		logic        ok;
		lookup_t     r;
		typ      = e.info & TypeMask;
		end_addr = e.value + e.size;
		ok = e.has_name && e.section != 16'd0 && query_val >= e.value &&
			(typ[3:0] == TypeFunc || typ[3:0] == TypeObject || typ[3:0] == TypeNone);
		if (ok) begin
			if (e.size != 64'd0 && query_val < end_addr) begin
				if (!have_cont || e.value > best.match_value) begin
					best      = capture(e, query_val);
					have_cont = 1'b1;
				end
			end else if (!have_cont && (!have_prec || e.value > best.match_value)) begin
				best      = capture(e, query_val);
				have_prec = 1'b1;
			end
		end
		if (e.last_entry) begin
			r = '0;
			if (have_cont || have_prec) begin
				r          = best;
				r.found    = 1'b1;
				r.contains = have_cont;
			end
			lookups_due.push_back(r);
			have_cont = 1'b0;
			have_prec = 1'b0;
			best      = '0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic send_entry(input sym_entry_t e);
		int unsigned gap;
		gap = pick_gap(gaps_on);
		if (gap != 0) begin
			entry_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		entry_if.valid       <= 1'b1;
		entry_if.sym_value   <= e.value;
		entry_if.sym_size    <= e.size;
		entry_if.sym_info    <= e.info;
		entry_if.sym_section <= e.section;
		entry_if.name_ref    <= e.name_ref;
		entry_if.has_name    <= e.has_name;
		entry_if.last_entry  <= e.last_entry;
		@(posedge clk);
		while (!entry_if.ready)
			@(posedge clk);
		track_nearest(e);
	endtask

	// stop the entry stream and let the pipeline empty out
	task automatic settle();
		entry_if.valid <= 1'b0;
		while (lookups_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_query(input logic [63:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= QueryAddrOffset;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		query_val = val;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic sym_entry_t make_entry(input logic [63:0] q, input logic last);
		sym_entry_t  e;
		int unsigned r;
		logic [63:0] off;
		off = ($urandom_range(0, 3) == 0) ? {32'd0, $urandom} : 64'($urandom_range(0, 12288));
		r = $urandom_range(0, 99);
		if (r < 55)
			e.value = q - off;
		else if (r < 65)
			e.value = q;
		else if (r < 80)
			e.value = q + 64'd1 + 64'($urandom_range(0, 4095));
		else
			e.value = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 25)
			e.size = '0;
		else if (r < 50)
			e.size = (q - e.value) + 64'($urandom_range(0, 64));
		else if (r < 70)
			e.size = 64'($urandom_range(1, 8192));
		else if (r < 78)
			e.size = '1;
		else if (r < 83)
			e.size = 64'd1;
		else
			e.size = {$urandom, $urandom};
		if ($urandom_range(0, 99) < 80)
			e.info = {4'($urandom_range(0, 15)), 4'($urandom_range(0, 2))};
		else
			e.info = 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 8)
			e.section = '0;
		else if (r < 12)
			e.section = '1;
		else
			e.section = 16'($urandom_range(1, 65535));
		e.name_ref   = $urandom;
		e.has_name   = ($urandom_range(0, 9) != 0);
		e.last_entry = last;
		return e;
	endfunction

	task automatic test_filtering();
		settle();
		write_query(64'h1000);
		send_entry(mk_sym(64'h800, 64'h0, 8'h02, 16'h1, 32'h11, 1'b1, 1'b0));
		// nameless, undefined, above the address, unknown type: all skipped
		send_entry(mk_sym(64'h900, 64'h0, 8'h02, 16'h1, 32'h12, 1'b0, 1'b0));
		send_entry(mk_sym(64'h900, 64'h0, 8'h02, 16'h0, 32'h13, 1'b1, 1'b0));
		send_entry(mk_sym(64'h2000, 64'h0, 8'h01, 16'h1, 32'h14, 1'b1, 1'b0));
		send_entry(mk_sym(64'h900, 64'h0, 8'h03, 16'h1, 32'h15, 1'b1, 1'b0));
		// high nibble of the info byte does not matter
		send_entry(mk_sym(64'h880, 64'h0, 8'hF1, 16'h2, 32'h16, 1'b1, 1'b1));
	endtask

	task automatic test_priority();
		settle();
		send_entry(mk_sym(64'hF00, 64'h200, 8'h02, 16'h1, 32'h21, 1'b1, 1'b0));
		send_entry(mk_sym(64'hFF0, 64'h0, 8'h00, 16'h1, 32'h22, 1'b1, 1'b0));
		send_entry(mk_sym(64'hF80, 64'h100, 8'h12, 16'h1, 32'h23, 1'b1, 1'b0));
		// equal start among containing entries keeps the earlier one
		send_entry(mk_sym(64'hF80, 64'h90, 8'h22, 16'h1, 32'h24, 1'b1, 1'b1));
		// equal start among preceding entries keeps the earlier one
		send_entry(mk_sym(64'h900, 64'h10, 8'h01, 16'h5, 32'h25, 1'b1, 1'b0));
		send_entry(mk_sym(64'h900, 64'h0, 8'h01, 16'h6, 32'h26, 1'b1, 1'b1));
		// nothing matches
		send_entry(mk_sym(64'h1001, 64'h10, 8'h02, 16'h1, 32'h27, 1'b1, 1'b1));
	endtask

	task automatic test_extremes();
		settle();
		write_query('0);
		send_entry(mk_sym('0, '1, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
		settle();
		write_query('1);
		// range wraps past the top, so it only counts as preceding
		send_entry(mk_sym(64'hFFFF_FFFF_FFFF_FF00, 64'h200, 8'h02, 16'h1, 32'h0, 1'b1, 1'b0));
		send_entry(mk_sym('1, 64'h1, 8'h01, 16'h3, 32'h1, 1'b1, 1'b0));
		send_entry(mk_sym('1, 64'h0, 8'h00, 16'h4, 32'h2, 1'b1, 1'b1));
	endtask

	task automatic test_mid_search_address();
		settle();
		write_query(64'h5000);
		send_entry(mk_sym(64'h4000, 64'h2000, 8'h02, 16'h7, 32'h31, 1'b1, 1'b0));
		settle();
		// offset stays the one taken against the old address
		write_query(64'h3000);
		send_entry(mk_sym(64'h2000, 64'h0, 8'h02, 16'h7, 32'h32, 1'b1, 1'b0));
		send_entry(mk_sym(64'h4000, 64'h0, 8'h02, 16'h7, 32'h33, 1'b1, 1'b1));
	endtask

	task automatic test_random_searches();
		int unsigned phase;
		int unsigned sent;
		int unsigned len;
		int unsigned k;
		logic [63:0] q;
		phase = 0;
		sent  = 0;
		while (sent < RandomItems) begin
			case (phase)
				0: q = '0;
				1: q = '1;
				default: begin
					case ($urandom_range(0, 3))
						0: q = 64'($urandom_range(0, 65535));
						1: q = '1 - 64'($urandom_range(0, 65535));
						default: q = {$urandom, $urandom};
					endcase
				end
			endcase
			settle();
			gaps_on   = (phase % 4) != 3;
			stalls_on = (phase % 3) != 2;
			write_query(q);
			repeat ($urandom_range(3, 8)) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
				for (k = 1; k <= len; k++)
					send_entry(make_entry(q, k == len));
				sent += len;
			end
			phase++;
		end
	endtask

	// result side stalls
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left--;
		else
			hold_left = pick_gap(stalls_on);
		result_if.ready <= (hold_left == 0);
	end

	always @(posedge clk) begin
		lookup_t got;
		lookup_t want;
		if (arst_n && result_if.valid === 1'b1 && result_if.ready) begin
			got.found          = result_if.found;
			got.contains       = result_if.contains;
			got.match_value    = result_if.match_value;
			got.match_size     = result_if.match_size;
			got.match_info     = result_if.match_info;
			got.match_section  = result_if.match_section;
			got.match_name_ref = result_if.match_name_ref;
			got.addr_offset    = result_if.addr_offset;
			if (lookups_due.size() == 0) begin
				report_mismatch("result word with no lookup pending");
			end else begin
				want = lookups_due.pop_front();
				compare_field("found", 64'(got.found), 64'(want.found));
				compare_field("contains", 64'(got.contains), 64'(want.contains));
				compare_field("match_value", got.match_value, want.match_value);
				compare_field("match_size", got.match_size, want.match_size);
				compare_field("match_info", 64'(got.match_info), 64'(want.match_info));
				compare_field("match_section", 64'(got.match_section), 64'(want.match_section));
				compare_field("match_name_ref", 64'(got.match_name_ref),
					64'(want.match_name_ref));
				compare_field("addr_offset", got.addr_offset, want.addr_offset);
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((entry_if.valid === 1'b1 && entry_if.ready === 1'b1) ||
				(result_if.valid === 1'b1 && result_if.ready === 1'b1) ||
				(psel && penable && pready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		entry_if.valid       = 1'b0;
		entry_if.sym_value   = '0;
		entry_if.sym_size    = '0;
		entry_if.sym_info    = '0;
		entry_if.sym_section = '0;
		entry_if.name_ref    = '0;
		entry_if.has_name    = 1'b0;
		entry_if.last_entry  = 1'b0;
		result_if.ready      = 1'b0;
		query_val            = '0;
		have_cont            = 1'b0;
		have_prec            = 1'b0;
		best                 = '0;
		mismatches           = 0;
		quiet_cycles         = 0;
		hold_left            = 0;
		gaps_on              = 1'b1;
		stalls_on            = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_filtering();
		test_priority();
		test_extremes();
		test_mid_search_address();
		test_random_searches();
		settle();
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
